>>> rtl/core/cpu_load_moving_average_unit_assert.svh
// assertion macros for the cpu load moving average unit
// the using module provides i_clk and i_rst_n
`ifndef CPU_LOAD_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define CPU_LOAD_MOVING_AVERAGE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLMA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLMA_ASSERT(lbl, ante, cons, msg)
`define CLMA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/clma_pkg.sv
package clma_pkg;

    // window and field widths
    localparam int WINDOW  = 8;
    localparam int TICK_W  = 32;
    localparam int PCT_W   = 7;
    localparam int PCT_MAX = 100;

    // divider sizing: quotient bits, shifted divisor and dividend
    localparam int QUO_W  = PCT_W;
    localparam int STEP_W = $clog2(QUO_W + 1);
    localparam int MULT_W = TICK_W + QUO_W;

    // ring bookkeeping
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * PCT_MAX + 1);

    // input word
    typedef struct packed {
        logic [TICK_W-1:0] user_ticks;
        logic [TICK_W-1:0] system_ticks;
        logic [TICK_W-1:0] nice_ticks;
        logic [TICK_W-1:0] idle_ticks;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [PCT_W-1:0] load_percent;
        logic             window_ready;
    } t_out_word;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_DIV,
        S_UPD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic diff;
        logic mul;
        logic div_step;
        logic div_first;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_ge;
        logic den_zero;
    } t_status;

endpackage

>>> rtl/core/clma_ctrl.sv
module clma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  clma_pkg::t_status i_status,
    output clma_pkg::t_cmd    o_cmd
);
    import clma_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                w_out_free;
    logic                w_first;
    logic                w_div_done;

    // output register can take a new word
    assign w_out_free = !r_out_valid || !i_out_stall;

    // divide finishes early on zero divisor or saturation, else after last bit
    assign w_first    = (r_step == STEP_W'(QUO_W));
    assign w_div_done = w_first ? (i_status.den_zero || i_status.div_ge) : (r_step == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and step counter
    always_comb begin
        o_cmd       = '0;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: o_cmd.load_in = i_in_valid;
            S_DIFF: o_cmd.diff = 1'b1;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = STEP_W'(QUO_W);
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = w_first;
                n_step          = r_step - 1'b1;
            end
            S_UPD: begin
                o_cmd.update = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/clma_datapath.sv
module clma_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clma_pkg::t_in_word  i_in_word,
    input  clma_pkg::t_cmd      i_cmd,
    output clma_pkg::t_status   o_status,
    output clma_pkg::t_out_word o_out_word
);
    import clma_pkg::*;

    // working registers
    logic [TICK_W-1:0] r_busy;
    logic [TICK_W-1:0] r_idle;
    logic [TICK_W-1:0] r_dbusy;
    logic [TICK_W-1:0] r_didle;
    logic [MULT_W-1:0] r_num;
    logic [MULT_W-1:0] r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic              r_sat;
    t_out_word         r_out;

    // state kept between words
    logic [TICK_W-1:0] r_prev_busy;
    logic [TICK_W-1:0] r_prev_idle;
    logic [PCT_W-1:0]  r_ring [WINDOW];
    logic [PTR_W-1:0]  r_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;

    logic              w_ge;
    logic [PCT_W-1:0]  w_dbusy_sat;
    logic [PCT_W-1:0]  w_sample;
    logic [SUM_W-1:0]  n_sum;
    logic [FILL_W-1:0] n_fill;
    logic [PTR_W-1:0]  n_ptr;
    logic              w_ready;

    // divide compare and status
    assign w_ge              = (r_num >= r_dsh);
    assign o_status.div_ge   = w_ge;
    assign o_status.den_zero = (r_dsh == '0);

    // zero total delta: busy delta clipped
    assign w_dbusy_sat = (r_dbusy > TICK_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : r_dbusy[PCT_W-1:0];

    // clipped sample
    assign w_sample = (r_sat || (r_quo > QUO_W'(PCT_MAX))) ? PCT_W'(PCT_MAX) : r_quo;

    // ring update values
    assign n_sum   = r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(w_sample);
    assign n_fill  = (r_fill == FILL_W'(WINDOW)) ? r_fill : r_fill + 1'b1;
    assign n_ptr   = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
    assign w_ready = (n_fill == FILL_W'(WINDOW));

    // arithmetic pipeline and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_busy <= i_in_word.user_ticks + i_in_word.system_ticks + i_in_word.nice_ticks;
            r_idle <= i_in_word.idle_ticks;
        end
        if (i_cmd.diff) begin
            r_dbusy <= r_busy - r_prev_busy;
            r_didle <= r_idle - r_prev_idle;
        end
        if (i_cmd.mul) begin
            r_num <= MULT_W'(r_dbusy) * MULT_W'(PCT_MAX);
            r_dsh <= {r_dbusy + r_didle, QUO_W'(0)};
            r_sat <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_dsh <= r_dsh >> 1;
            if (i_cmd.div_first) begin
                if (o_status.den_zero) begin
                    r_quo <= w_dbusy_sat;
                end else if (w_ge) begin
                    r_sat <= 1'b1;
                end
            end else begin
                if (w_ge) begin
                    r_num <= r_num - r_dsh;
                end
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
            end
        end
        if (i_cmd.update) begin
            r_out.window_ready <= w_ready;
            r_out.load_percent <= w_ready ? PCT_W'(n_sum / WINDOW) : '0;
        end
    end

    // history, ring and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_busy <= '0;
            r_prev_idle <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (i_cmd.diff) begin
                r_prev_busy <= r_busy;
                r_prev_idle <= r_idle;
            end
            if (i_cmd.update) begin
                r_ring[r_ptr] <= w_sample;
                r_sum         <= n_sum;
                r_ptr         <= n_ptr;
                r_fill        <= n_fill;
            end
        end
    end

    assign o_out_word = r_out;

endmodule

>>> rtl/core/cpu_load_moving_average_unit.sv
// channel | direction | handshake                | word
// --------+-----------+--------------------------+-----------------------------
// in      | input     | i_in_valid / o_in_stall  | i_in_word  (four tick counts)
// out     | output    | o_out_valid / i_out_stall| o_out_word (load, ready flag)
//
// one word at a time: after acceptance, delta and multiply steps, then the
// restoring divider works bit-serially and stops at its first step on a zero
// divisor or saturation, then the update step writes ring and result
// synchronous active-low reset clears history, ring, fill count and running sum
// a stalled result waits in the output register; the next word is accepted meanwhile
// and held at the update step until the output register frees up

`include "cpu_load_moving_average_unit_assert.svh"

module cpu_load_moving_average_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clma_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clma_pkg::t_out_word o_out_word
);
    import clma_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_accept;
    logic    w_pct_ok;

    // sequencer
    clma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and ring
    clma_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

    // terms for the checks
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_pct_ok    = (o_out_word.load_percent <= PCT_W'(PCT_MAX)) &&
                         (o_out_word.window_ready || (o_out_word.load_percent == '0));

    // checks
    `CLMA_ASSERT_NEXT(a_busy_after_accept, w_in_accept, o_in_stall, "no busy after accept")
    `CLMA_ASSERT(a_out_from_update, $rose(o_out_valid), $past(w_cmd.update), "valid w/o update")
    `CLMA_ASSERT(a_pct_range, o_out_valid, w_pct_ok, "load out of range or early nonzero")

endmodule

>>> bench/tb_cpu_load_moving_average_unit.sv
module tb_cpu_load_moving_average_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import clma_pkg::*;

    localparam int LIMIT = 200000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // words waiting to be offered and loads waiting to come out
    t_in_word  tick_words[$];
    t_out_word load_expect[$];

    // predictor state
    logic [TICK_W-1:0] last_busy  = '0;
    logic [TICK_W-1:0] last_total = '0;
    logic [PCT_W-1:0]  ring_pct [WINDOW] = '{default: '0};
    int                ring_wr       = 0;
    int                samples_taken = 0;
    int                ring_total    = 0;

    // cumulative counters behind the generated words
    logic [TICK_W-1:0] cum_user, cum_sys, cum_nice, cum_idle;

    // run control and bookkeeping
    bit        idle_on    = 1'b1;
    int        send_gap   = 0;
    int        stall_gap  = 0;
    int        hold_left  = 0;
    int        hold_mark  = -1;
    int        n_words_in = 0;
    int        n_results  = 0;
    int        n_errors   = 0;
    int        n_full     = 0;
    int        n_zero_tot = 0;
    int        n_blocked  = 0;
    int        n_cycles   = 0;
    t_out_word want;

    cpu_load_moving_average_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one load sample from the tick deltas, clamped at full load
    function automatic logic [PCT_W-1:0] busy_percent(logic [TICK_W-1:0] d_busy,
                                                      logic [TICK_W-1:0] d_total);
        logic [63:0] q;
        if (d_total != '0)
            q = ({32'd0, d_busy} * 64'd100) / {32'd0, d_total};
        else
            q = {32'd0, d_busy};
        if (q > PCT_MAX)
            q = PCT_MAX;
        return q[PCT_W-1:0];
    endfunction

    // advance the load history by one word and queue the load it yields
    task automatic predict_load(t_in_word w);
        logic [TICK_W-1:0] busy;
        logic [TICK_W-1:0] total;
        logic [PCT_W-1:0]  pct;
        int                mean;
        t_out_word         r;
        busy  = w.user_ticks + w.system_ticks + w.nice_ticks;
        total = busy + w.idle_ticks;
        if (total == last_total)
            n_zero_tot++;
        pct = busy_percent(busy - last_busy, total - last_total);
        if (pct == PCT_MAX)
            n_full++;
        last_busy  = busy;
        last_total = total;
        ring_total = ring_total - ring_pct[ring_wr] + pct;
        ring_pct[ring_wr] = pct;
        ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
        if (samples_taken < WINDOW)
            samples_taken++;
        mean = ring_total / WINDOW;
        r.window_ready = (samples_taken == WINDOW);
        r.load_percent = r.window_ready ? mean[PCT_W-1:0] : '0;
        load_expect.push_back(r);
    endtask

    // queue a word with absolute counter values
    task automatic load_ticks(logic [TICK_W-1:0] u, logic [TICK_W-1:0] s,
                              logic [TICK_W-1:0] n, logic [TICK_W-1:0] i);
        t_in_word w;
        cum_user = u;
        cum_sys  = s;
        cum_nice = n;
        cum_idle = i;
        w.user_ticks   = u;
        w.system_ticks = s;
        w.nice_ticks   = n;
        w.idle_ticks   = i;
        tick_words.push_back(w);
    endtask

    // queue a word that moves each counter on by the given amount
    task automatic advance_ticks(logic [TICK_W-1:0] du, logic [TICK_W-1:0] ds,
                                 logic [TICK_W-1:0] dn, logic [TICK_W-1:0] di);
        load_ticks(cum_user + du, cum_sys + ds, cum_nice + dn, cum_idle + di);
    endtask

    // one random word: mostly plausible counter progress, some jumps and noise
    task automatic random_step(int profile);
        logic [TICK_W-1:0] dt, db, du, ds, dn;
        case ($urandom_range(0, 9))
            0: load_ticks($urandom, $urandom, $urandom, $urandom);
            1: begin
                // busy moves while total stays put
                du = $urandom_range(0, 200);
                ds = $urandom_range(0, 200);
                dn = $urandom_range(0, 3);
                advance_ticks(du, ds, dn, 32'd0 - (du + ds + dn));
            end
            2: advance_ticks($urandom, $urandom, $urandom, $urandom);
            default: begin
                dt = $urandom_range(1, 2000);
                case (profile)
                    1:       db = dt;
                    2:       db = 0;
                    3:       db = $urandom_range(dt - dt / 8, dt);
                    default: db = $urandom_range(0, dt);
                endcase
                du = $urandom_range(0, db);
                ds = $urandom_range(0, db - du);
                advance_ticks(du, ds, db - du - ds, dt - db);
            end
        endcase
    endtask

    // hold until nothing is queued, offered or owed
    task automatic wait_drained();
        while (tick_words.size() != 0 || i_in_valid || load_expect.size() != 0)
            @(negedge i_clk);
    endtask

    // sender: offers queued words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // a word moves on this edge
            if (i_in_valid && !o_in_stall) begin
                predict_load(i_in_word);
                n_words_in++;
            end
            if (i_in_valid && o_in_stall)
                n_blocked++;
            // pick the next offer once the current word is gone
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_words.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    i_in_valid <= 1'b0;
                end else if (tick_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= tick_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each load word and stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (load_expect.size() == 0) begin
                    $display("%0t: unexpected word load_percent=%0d window_ready=%0d",
                             $time, o_out_word.load_percent, o_out_word.window_ready);
                    n_errors++;
                end else begin
                    want = load_expect.pop_front();
                    if (o_out_word.load_percent !== want.load_percent) begin
                        $display("%0t: load_percent expected %0d actual %0d",
                                 $time, want.load_percent, o_out_word.load_percent);
                        n_errors++;
                    end
                    if (o_out_word.window_ready !== want.window_ready) begin
                        $display("%0t: window_ready expected %0d actual %0d",
                                 $time, want.window_ready, o_out_word.window_ready);
                        n_errors++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_left == 0 && n_results % 700 == 300 && n_results != hold_mark) begin
                hold_mark = n_results;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("%0t: timeout with %0d loads outstanding", $time, load_expect.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        int c;
        int k;
        int profile;
        profile = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        load_ticks(0, 0, 0, 0);                         // first word against zero history
        advance_ticks(50, 0, 0, -32'd50);               // total unchanged, busy up 50
        advance_ticks(0, 300, 0, -32'd300);             // total unchanged, busy clamps
        load_ticks('1, '1, '1, '1);                     // all counters at maximum
        load_ticks(0, 0, 0, 0);                         // every counter wraps to zero
        advance_ticks(0, 0, 0, 1000);                   // idle only
        advance_ticks(250, 250, 0, 500);                // half busy
        advance_ticks(1, 0, 0, 2);                      // one in three, truncated
        advance_ticks(0, 0, 6, 1);                      // six in seven
        advance_ticks(-32'd400, 0, 0, 450);             // busy steps back, quotient clamps
        load_ticks(32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_000F);
        advance_ticks(32'h20, 32'h10, 32'h10, 32'h40);  // counters wrap past the top
        advance_ticks(0, 0, 0, 0);                      // nothing moved
        advance_ticks(100, 0, 0, 0);                    // fully busy
        for (k = 0; k < 10; k++)
            advance_ticks($urandom_range(0, 50), $urandom_range(0, 50),
                          $urandom_range(0, 50), $urandom_range(0, 100));
        wait_drained();

        // random sequences in chunks; quiet ending without idling
        for (c = 0; c < 5; c++) begin
            if (c == 4)
                idle_on = 1'b0;
            for (k = 0; k < ((c == 4) ? 200 : 300); k++) begin
                if (k % 20 == 0)
                    profile = $urandom_range(0, 3);
                random_step(profile);
            end
            // sender pause after the second chunk, otherwise just keep feeding
            if (c == 1)
                wait_drained();
            else
                while (tick_words.size() != 0)
                    @(negedge i_clk);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d words and %0d load words in %0d cycles",
                 n_words_in, n_results, n_cycles);
        $display("%0d clamped samples, %0d zero total deltas, %0d cycles of input held off",
                 n_full, n_zero_tot, n_blocked);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
